// ===== hdl/timeslice_max_counter_scheduler_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Clocked assertion shorthands shared by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef TIMESLICE_MAX_COUNTER_SCHEDULER_UNIT_ASSERT_SVH
`define TIMESLICE_MAX_COUNTER_SCHEDULER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked outside reset
`define TMCS_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked outside reset
`define TMCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TMCS_ASSERT(lbl, ante, cons, msg)
`define TMCS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/tmcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Scheduler package
// Field widths, action and status codes, sequencer states and the
// request/result bundles passed between the stream wrapper and the core.
// ----------------------------------------------------------------------------
package tmcs_pkg;

    localparam int ACTION_W      = 2;
    localparam int SLOT_FIELD_W  = 4;
    localparam int SLICE_FIELD_W = 10;
    localparam int COUNT_FIELD_W = 5;
    localparam int STATUS_W      = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK   = 2'd0,
        ACT_SCHED  = 2'd1,
        ACT_ADD    = 2'd2,
        ACT_REMOVE = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK             = 2'd0,
        STAT_ADD_REFUSED    = 2'd1,
        STAT_REMOVE_REFUSED = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_TICK_WR,
        ST_SCHED_CHK,
        ST_UNLINK,
        ST_APPEND,
        ST_SCAN,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        action_t                  action;
        logic [SLOT_FIELD_W-1:0]  task_slot;
        logic [SLICE_FIELD_W-1:0] time_slice;
    } req_t;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0]  running_slot;
        logic                     running_idle;
        logic                     switched;
        logic                     resched_needed;
        status_t                  status;
        logic [COUNT_FIELD_W-1:0] queued_count;
    } res_t;

endpackage

// ===== hdl/tmcs_core.sv =====
// ----------------------------------------------------------------------------
// Scheduler core
// Run-queue, counter and timeslice memories under a small sequencer. The
// queue-order memory is streamed one entry per cycle for unlinking and for
// the largest-counter scan, which shares a single compare unit.
// ----------------------------------------------------------------------------
`include "timeslice_max_counter_scheduler_unit_assert.svh"

module tmcs_core #(
    parameter int TASK_SLOTS = 16,
    parameter int COUNT_BITS = 10
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           req_valid,
    output logic           req_ready,
    input  tmcs_pkg::req_t req_in,
    output logic           res_valid,
    input  logic           res_ready,
    output tmcs_pkg::res_t res
);
    import tmcs_pkg::*;

    localparam int SB = $clog2(TASK_SLOTS);
    localparam int LB = $clog2(TASK_SLOTS + 1);

    // sequencer and control state
    seq_state_t              state_reg, state_next;
    logic [SB-1:0]           cur_slot_reg, cur_slot_next;
    logic                    cur_idle_reg, cur_idle_next;
    logic [LB-1:0]           len_reg, len_next;
    logic [TASK_SLOTS-1:0]   queued_reg, queued_next;
    logic [TASK_SLOTS-1:0]   resched_reg, resched_next;
    logic                    p1_reg, p1_next;
    logic                    p2_reg, p2_next;

    // payload state
    req_t                    req_reg, req_next;
    logic [LB-1:0]           ri_reg, ri_next;
    logic [LB-1:0]           wj_reg, wj_next;
    logic [SB-1:0]           target_reg, target_next;
    logic [COUNT_BITS-1:0]   best_reg, best_next;
    logic                    found_reg, found_next;
    logic [SB-1:0]           pick_reg, pick_next;
    logic [SB-1:0]           s2_reg, s2_next;
    status_t                 status_reg, status_next;
    logic                    sw_reg, sw_next;

    // memories
    logic [SB-1:0]         order_mem [TASK_SLOTS];
    logic [COUNT_BITS-1:0] ctr_mem   [TASK_SLOTS];
    logic [COUNT_BITS-1:0] slc_mem   [TASK_SLOTS];

    logic                  order_we;
    logic [SB-1:0]         order_wa, order_wd, order_ra, order_rd;
    logic                  ctr_we;
    logic [SB-1:0]         ctr_wa, ctr_ra;
    logic [COUNT_BITS-1:0] ctr_wd, ctr_rd;
    logic                  slc_we;
    logic [COUNT_BITS-1:0] slc_rd;

    // request decode
    logic [SB-1:0]         req_idx;
    logic                  slot_ok, len_full, add_ok, rm_ok;
    logic [COUNT_BITS-1:0] slice_in, ctr_dec;
    logic                  unlink_done, scan_done, better;

    assign req_idx     = SB'(req_reg.task_slot);
    assign slot_ok     = (32'(req_reg.task_slot) < TASK_SLOTS);
    assign len_full    = (len_reg >= LB'(TASK_SLOTS));
    assign add_ok      = slot_ok && !queued_reg[req_idx] && !len_full;
    assign rm_ok       = slot_ok && queued_reg[req_idx];
    assign slice_in    = COUNT_BITS'(req_reg.time_slice);
    assign ctr_dec     = (ctr_rd == '0) ? '0 : ctr_rd - 1'b1;
    assign unlink_done = (ri_reg == len_reg) && !p1_reg;
    assign scan_done   = (ri_reg == len_reg) && !p1_reg && !p2_reg;
    assign better      = !found_reg || (ctr_rd > best_reg);

    // memory ports: one write, one registered read each
    always_ff @(posedge aclk) begin
        if (order_we) begin
            order_mem[order_wa] <= order_wd;
        end
        order_rd <= order_mem[order_ra];
    end

    always_ff @(posedge aclk) begin
        if (ctr_we) begin
            ctr_mem[ctr_wa] <= ctr_wd;
        end
        ctr_rd <= ctr_mem[ctr_ra];
    end

    always_ff @(posedge aclk) begin
        if (slc_we) begin
            slc_mem[req_idx] <= slice_in;
        end
        slc_rd <= slc_mem[cur_slot_reg];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (req_reg.action)
                    ACT_TICK:   state_next = cur_idle_reg ? ST_DONE : ST_TICK_WR;
                    ACT_ADD:    state_next = ST_DONE;
                    ACT_REMOVE: state_next = rm_ok ? ST_UNLINK : ST_DONE;
                    ACT_SCHED: begin
                        state_next = (!cur_idle_reg && queued_reg[cur_slot_reg]) ?
                                     ST_SCHED_CHK : ST_SCAN;
                    end
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_TICK_WR:   state_next = ST_DONE;
            ST_SCHED_CHK: state_next = (ctr_rd == '0) ? ST_UNLINK : ST_SCAN;
            ST_UNLINK: begin
                if (unlink_done) begin
                    state_next = (req_reg.action == ACT_SCHED) ? ST_APPEND : ST_DONE;
                end
            end
            ST_APPEND: state_next = ST_SCAN;
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        req_next      = req_reg;
        cur_slot_next = cur_slot_reg;
        cur_idle_next = cur_idle_reg;
        len_next      = len_reg;
        queued_next   = queued_reg;
        resched_next  = resched_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        ri_next       = ri_reg;
        wj_next       = wj_reg;
        target_next   = target_reg;
        best_next     = best_reg;
        found_next    = found_reg;
        pick_next     = pick_reg;
        s2_next       = s2_reg;
        status_next   = status_reg;
        sw_next       = sw_reg;
        order_we      = 1'b0;
        order_wa      = SB'(len_reg);
        order_wd      = req_idx;
        order_ra      = SB'(ri_reg);
        ctr_we        = 1'b0;
        ctr_wa        = cur_slot_reg;
        ctr_wd        = ctr_dec;
        ctr_ra        = cur_slot_reg;
        slc_we        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    req_next = req_in;
                end
            end
            ST_DISPATCH: begin
                status_next = STAT_OK;
                sw_next     = 1'b0;
                ri_next     = '0;
                wj_next     = '0;
                p1_next     = 1'b0;
                p2_next     = 1'b0;
                found_next  = 1'b0;
                case (req_reg.action)
                    ACT_ADD: begin
                        if (add_ok) begin
                            slc_we               = 1'b1;
                            ctr_we               = 1'b1;
                            ctr_wa               = req_idx;
                            ctr_wd               = slice_in;
                            resched_next[req_idx] = 1'b0;
                            queued_next[req_idx]  = 1'b1;
                            order_we             = 1'b1;
                            len_next             = len_reg + 1'b1;
                        end else begin
                            status_next = STAT_ADD_REFUSED;
                        end
                    end
                    ACT_REMOVE: begin
                        if (rm_ok) begin
                            queued_next[req_idx] = 1'b0;
                            target_next          = req_idx;
                        end else begin
                            status_next = STAT_REMOVE_REFUSED;
                        end
                    end
                    ACT_SCHED: begin
                        target_next = cur_slot_reg;
                        if (!cur_idle_reg) begin
                            resched_next[cur_slot_reg] = 1'b0;
                        end
                    end
                    default: begin
                        // tick: counter read of the current slot is already addressed
                    end
                endcase
            end
            ST_TICK_WR: begin
                ctr_we = 1'b1;
                if (ctr_dec == '0) begin
                    resched_next[cur_slot_reg] = 1'b1;
                end
            end
            ST_SCHED_CHK: begin
                // expired slice: reload the counter, then requeue at the tail
                if (ctr_rd == '0) begin
                    ctr_we = 1'b1;
                    ctr_wd = slc_rd;
                end
            end
            ST_UNLINK: begin
                // compact the queue, dropping the target slot
                if (ri_reg < len_reg) begin
                    ri_next = ri_reg + 1'b1;
                    p1_next = 1'b1;
                end else begin
                    p1_next = 1'b0;
                end
                if (p1_reg && (order_rd != target_reg)) begin
                    order_we = 1'b1;
                    order_wa = SB'(wj_reg);
                    order_wd = order_rd;
                    wj_next  = wj_reg + 1'b1;
                end
                if (unlink_done) begin
                    len_next = wj_reg;
                    ri_next  = '0;
                end
            end
            ST_APPEND: begin
                order_we = 1'b1;
                order_wd = target_reg;
                len_next = len_reg + 1'b1;
            end
            ST_SCAN: begin
                // three-step stream: order read, counter read, compare
                if (ri_reg < len_reg) begin
                    ri_next = ri_reg + 1'b1;
                    p1_next = 1'b1;
                end else begin
                    p1_next = 1'b0;
                end
                ctr_ra  = order_rd;
                s2_next = order_rd;
                p2_next = p1_reg;
                if (p2_reg && better) begin
                    best_next  = ctr_rd;
                    pick_next  = s2_reg;
                    found_next = 1'b1;
                end
                if (scan_done) begin
                    cur_idle_next = !found_reg;
                    cur_slot_next = found_reg ? pick_reg : '0;
                    sw_next       = found_reg ? (cur_idle_reg || (cur_slot_reg != pick_reg))
                                              : !cur_idle_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // handshake and result outputs
    always_comb begin
        req_ready          = (state_reg == ST_IDLE);
        res_valid          = (state_reg == ST_DONE);
        res.running_slot   = cur_idle_reg ? '0 : SLOT_FIELD_W'(cur_slot_reg);
        res.running_idle   = cur_idle_reg;
        res.switched       = sw_reg;
        res.resched_needed = !cur_idle_reg && resched_reg[cur_slot_reg];
        res.status         = status_reg;
        res.queued_count   = COUNT_FIELD_W'(len_reg);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cur_slot_reg <= '0;
            cur_idle_reg <= 1'b1;
            len_reg      <= '0;
            queued_reg   <= '0;
            resched_reg  <= '0;
            p1_reg       <= 1'b0;
            p2_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_slot_reg <= cur_slot_next;
            cur_idle_reg <= cur_idle_next;
            len_reg      <= len_next;
            queued_reg   <= queued_next;
            resched_reg  <= resched_next;
            p1_reg       <= p1_next;
            p2_reg       <= p2_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        ri_reg     <= ri_next;
        wj_reg     <= wj_next;
        target_reg <= target_next;
        best_reg   <= best_next;
        found_reg  <= found_next;
        pick_reg   <= pick_next;
        s2_reg     <= s2_next;
        status_reg <= status_next;
        sw_reg     <= sw_next;
    end

    `TMCS_ASSERT(a_len_bound, 1'b1, len_reg <= LB'(TASK_SLOTS), "queue length above slot count")
    `TMCS_ASSERT(a_len_matches, state_reg == ST_IDLE, $countones(queued_reg) == int'(len_reg), "queue length differs from queued slots")
    `TMCS_ASSERT(a_pick_queued, state_reg == ST_DONE && req_reg.action == ACT_SCHED && !cur_idle_reg, queued_reg[cur_slot_reg], "scheduled task not in run queue")
    `TMCS_ASSERT_NEXT(a_res_hold, state_reg == ST_DONE && !res_ready, state_reg == ST_DONE && $stable(res), "result changed while waiting")

endmodule

// ===== hdl/timeslice_max_counter_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// Timeslice max-counter scheduler
// Stream wrapper around the scheduler core with a registered result stage.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. Each action is taken whole before
// the next is accepted; the run-queue memory is walked one entry per cycle.
// A schedule that rotates the current task unlinks it from the queue over
// the queued entries through the read pipeline, appends it at the tail,
// then scans the queued entries for the largest counter through the shared
// compare unit. A schedule that does not rotate the current task skips
// unlink and append and goes straight to the largest-counter scan.
// A finished result sits in the output register, and the next transfer can
// be accepted while it waits. No clearing pass runs after reset.
module timeslice_max_counter_scheduler_unit #(
    parameter int TASK_SLOTS = 16,
    parameter int COUNT_BITS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // task_slot[3:0], time_slice[13:4], zero[15:14]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // running_slot[3:0], running_idle[4], switched[5],
                                   // resched_needed[6], status[8:7],
                                   // queued_count[13:9], zero[15:14]
);
    import tmcs_pkg::*;

    req_t        req;
    res_t        res;
    logic        res_valid, res_ready, req_ready;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg, m_tdata_next;

    // unpack the input transfer
    assign req.action     = action_t'(s_tuser);
    assign req.task_slot  = s_tdata[3:0];
    assign req.time_slice = s_tdata[13:4];
    assign s_tready       = req_ready;

    tmcs_core #(
        .TASK_SLOTS (TASK_SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (req_ready),
        .req_in    (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // result register: free when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            if (res_valid) begin
                m_tdata_next = {2'b00, res.queued_count, res.status, res.resched_needed,
                                res.switched, res.running_idle, res.running_slot};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
